// ----- rtl/dcc_pkg.sv -----
// Shared types, constants and helper functions for the DCC bit sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dcc_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 8;

  localparam logic [4:0] PREAMBLE_RESET = 5'd14;
  localparam logic [4:0] CUTOUT_STEPS   = 5'd4;
  localparam logic [4:0] TOP_BIT        = 5'd7;
  localparam logic [4:0] STOP_MARK      = 5'd8;

  localparam int IDLE_PKT_LEN  = 3;
  localparam int RESET_PKT_LEN = 3;

  localparam logic [2:0] PWR_OFF     = 3'd0;
  localparam logic [2:0] PWR_QUARTER = 3'd1;
  localparam logic [2:0] PWR_FULL    = 3'd4;

  typedef enum logic [0:0] {
    CFG_PREAMBLE_LEN     = 1'b0,
    CFG_START_WITH_RESET = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_IDLE = 2'd1,
    SRC_A    = 2'd2,
    SRC_B    = 2'd3
  } src_t;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
    logic       byte_last;
  } in_item_t;

  typedef struct packed {
    logic       is_bit;
    logic       track_bit;
    logic [2:0] power_quarters;
    logic       cutout_begin;
    logic       packet_begin;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  function automatic logic [7:0] idle_byte(logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'hFF;
      2'd1:    b = 8'h00;
      2'd2:    b = 8'hFF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/dcc_in_stage.sv -----
// Input register of the DCC bit sequencer: holds one accepted transaction.
// Depends on dcc_pkg.
`timescale 1ns / 1ps

module dcc_in_stage
  import dcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  in_item_t item,
  input  logic     take,
  output stage_t   held
);

  logic     valid;
  in_item_t data;

  assign item_ready = !valid || take;
  assign held.valid = valid;
  assign held.item  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item_ready) begin
      valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      data <= item;
    end
  end

endmodule

// ----- rtl/dcc_step.sv -----
// Sequencer state, packet buffers and one-step next-bit logic.
// Depends on dcc_pkg.
`timescale 1ns / 1ps

module dcc_step
  import dcc_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [0:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  stage_t     held,
  input  logic       fire,
  output out_item_t  res
);

  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_PACKET_BYTES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_BYTES);

  typedef enum logic [1:0] {
    PH_CUTOUT   = 2'd0,
    PH_PREAMBLE = 2'd1,
    PH_DATA     = 2'd2
  } phase_t;

  logic [4:0]       preamble_len;
  logic             start_with_reset;
  phase_t           phase, phase_next;
  logic [4:0]       bit_count, bit_count_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [CNT_W-1:0] len_a, len_a_next, len_b, len_b_next;
  src_t             cur, cur_next, pending, pending_next;
  logic [CNT_W-1:0] load_count, load_count_next;
  logic             load_target, load_target_next;

  logic [7:0] buffer_a [MAX_PACKET_BYTES];
  logic [7:0] buffer_b [MAX_PACKET_BYTES];

  logic             buf_we, buf_sel, reset_fill;
  logic [IDX_W-1:0] buf_idx;
  logic [4:0]       preamble_start;
  src_t             src_eff, tsrc;
  logic [CNT_W-1:0] len_a_eff, n, count_inc;
  logic [7:0]       rd_byte;
  logic             tgt;

  assign preamble_start = (preamble_len == 5'd0) ? 5'd0 : preamble_len - 5'd1;

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    byte_index_next  = byte_index;
    len_a_next       = len_a;
    len_b_next       = len_b;
    cur_next         = cur;
    pending_next     = pending;
    load_count_next  = load_count;
    load_target_next = load_target;
    buf_we     = 1'b0;
    buf_sel    = load_target;
    buf_idx    = load_count[IDX_W-1:0];
    reset_fill = 1'b0;
    src_eff    = cur;
    len_a_eff  = len_a;
    n          = CNT_W'(IDLE_PKT_LEN);
    rd_byte    = 8'h00;
    tgt        = load_target;
    tsrc       = load_target ? SRC_B : SRC_A;
    count_inc  = load_count;
    res        = '0;

    if (held.item.action) begin
      if (load_count == '0) begin
        tgt  = (cur == SRC_NONE) || (cur == SRC_A);
        tsrc = tgt ? SRC_B : SRC_A;
        if (pending == tsrc) pending_next = SRC_IDLE;
      end
      load_target_next = tgt;
      buf_sel          = tgt;
      if (load_count < MAX_CNT) begin
        buf_we    = 1'b1;
        count_inc = load_count + CNT_W'(1);
      end
      if (held.item.byte_last) begin
        if (tgt) len_b_next = count_inc;
        else len_a_next = count_inc;
        pending_next    = tsrc;
        load_count_next = '0;
      end else begin
        load_count_next = count_inc;
      end
    end else begin
      res.is_bit         = 1'b1;
      res.track_bit      = 1'b1;
      res.power_quarters = PWR_FULL;
      unique case (phase)
        PH_CUTOUT: begin
          if (bit_count == CUTOUT_STEPS) begin
            res.power_quarters = PWR_QUARTER;
            res.cutout_begin   = 1'b1;
            bit_count_next     = bit_count - 5'd1;
          end else if (bit_count != 5'd0) begin
            res.power_quarters = PWR_OFF;
            bit_count_next     = bit_count - 5'd1;
          end else begin
            phase_next     = PH_PREAMBLE;
            bit_count_next = preamble_start;
          end
        end
        PH_PREAMBLE: begin
          if (bit_count != 5'd0) begin
            bit_count_next = bit_count - 5'd1;
          end else begin
            res.track_bit   = 1'b0;
            phase_next      = PH_DATA;
            byte_index_next = '0;
            bit_count_next  = TOP_BIT;
          end
        end
        PH_DATA: begin
          if (byte_index == '0 && bit_count == TOP_BIT) begin
            if (pending == SRC_NONE) begin
              if (start_with_reset) begin
                reset_fill = 1'b1;
                src_eff    = SRC_A;
                len_a_eff  = CNT_W'(RESET_PKT_LEN);
                len_a_next = CNT_W'(RESET_PKT_LEN);
              end else begin
                src_eff = SRC_IDLE;
              end
            end else begin
              src_eff = pending;
            end
            cur_next         = src_eff;
            pending_next     = SRC_IDLE;
            res.packet_begin = 1'b1;
          end
          unique case (src_eff)
            SRC_A: begin
              n       = len_a_eff;
              rd_byte = reset_fill ? 8'h00 : buffer_a[byte_index];
            end
            SRC_B: begin
              n       = len_b;
              rd_byte = buffer_b[byte_index];
            end
            default: begin
              n       = CNT_W'(IDLE_PKT_LEN);
              rd_byte = (byte_index < IDX_W'(IDLE_PKT_LEN)) ? idle_byte(byte_index[1:0])
                                                             : 8'h00;
            end
          endcase
          if (n == '0) n = CNT_W'(1);
          if (n > MAX_CNT) n = MAX_CNT;
          if (bit_count >= STOP_MARK) begin
            if (CNT_W'(byte_index) + CNT_W'(1) >= n) begin
              res.track_bit  = 1'b1;
              phase_next     = PH_CUTOUT;
              bit_count_next = CUTOUT_STEPS;
            end else begin
              res.track_bit   = 1'b0;
              byte_index_next = byte_index + IDX_W'(1);
              bit_count_next  = TOP_BIT;
            end
          end else begin
            res.track_bit  = rd_byte[bit_count[2:0]];
            bit_count_next = (bit_count == 5'd0) ? STOP_MARK : bit_count - 5'd1;
          end
        end
        default: begin
          phase_next = PH_PREAMBLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_len     <= PREAMBLE_RESET;
      start_with_reset <= 1'b0;
      phase            <= PH_PREAMBLE;
      bit_count        <= PREAMBLE_RESET - 5'd1;
      byte_index       <= '0;
      len_a            <= '0;
      len_b            <= '0;
      cur              <= SRC_NONE;
      pending          <= SRC_NONE;
      load_count       <= '0;
      load_target      <= 1'b1;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_PREAMBLE_LEN:     preamble_len     <= cfg_data;
          CFG_START_WITH_RESET: start_with_reset <= cfg_data[0];
          default: ;
        endcase
      end
      if (fire) begin
        phase       <= phase_next;
        bit_count   <= bit_count_next;
        byte_index  <= byte_index_next;
        len_a       <= len_a_next;
        len_b       <= len_b_next;
        cur         <= cur_next;
        pending     <= pending_next;
        load_count  <= load_count_next;
        load_target <= load_target_next;
      end
    end
  end

  // buffer contents: no reset
  always_ff @(posedge clk) begin
    if (fire && buf_we) begin
      if (buf_sel) buffer_b[buf_idx] <= held.item.byte_value;
      else buffer_a[buf_idx] <= held.item.byte_value;
    end
    if (fire && reset_fill) begin
      for (int k = 0; k < RESET_PKT_LEN; k++) begin
        buffer_a[IDX_W'(k)] <= 8'h00;
      end
    end
  end

`ifndef SYNTHESIS
  a_load_result_zero: assert property (@(posedge clk) disable iff (rst)
    fire && held.item.action |-> res == '0)
    else $error("load transaction produced a non-zero result");

  a_cutout_entry: assert property (@(posedge clk) disable iff (rst)
    fire && res.cutout_begin |=> phase == PH_CUTOUT && bit_count == CUTOUT_STEPS - 5'd1)
    else $error("cutout did not advance after its first bit");

  a_packet_source: assert property (@(posedge clk) disable iff (rst)
    fire && res.packet_begin |=> cur != SRC_NONE && pending == SRC_IDLE)
    else $error("packet switch left no source selected");

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= MAX_CNT)
    else $error("load count beyond buffer capacity");
`endif

endmodule

// ----- rtl/dcc_bit_sequencer_with_cutout.sv -----
// DCC bit sequencer with RailCom cutout: top level.
// Instantiates dcc_in_stage and dcc_step; uses dcc_pkg.
//
// Usage: each input transaction is either a bit tick (action 0), which yields
// the next track bit with its power quarters and cutout/packet markers, or a
// packet byte load (action 1), which yields an all-zero result. Every input
// transaction yields exactly one result transaction, in order.
// Both channels are valid/ready. The input register takes a transaction
// whenever it is empty or its content moves on in the same cycle; the step
// logic then updates the sequencer state and loads the result register.
// An accepted transaction is registered in the input register and then in the
// result register. Throughput: one transaction per cycle while the receiver
// does not stall, through the step logic between input and result registers.
// When the receiver stalls, the result holds and one further transaction is
// held in the input register; beyond that item_ready drops.
// Reset (rst, synchronous): both registers empty, preamble of 13 ones
// starts, no packet buffered, first packet idle unless configured as reset.
// Configuration: cfg_write_en with cfg_index 0 = preamble length, 1 =
// start_with_reset; write only while the block is idle.
`timescale 1ns / 1ps

module dcc_bit_sequencer_with_cutout
  import dcc_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [0:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       item_valid,
  output logic       item_ready,
  input  in_item_t   item,
  output logic       result_valid,
  input  logic       result_ready,
  output out_item_t  result
);

  stage_t    held;
  logic      fire;
  out_item_t step_res;

  assign fire = held.valid && (!result_valid || result_ready);

  dcc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .take       (fire),
    .held       (held)
  );

  dcc_step #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .held         (held),
    .fire         (fire),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= step_res;
    end
  end

endmodule
